// File: rtl/hiws_pkg.sv
// shared types and constants for the inverse haar block with shrinkage
`timescale 1ns / 1ps
package hiws_pkg;

    localparam int COEF_W  = 20;
    localparam int THR_W   = 19;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 19;

    localparam logic [CFG_IDX_W-1:0] CFG_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_THR  = 2'd1;

    typedef enum logic [1:0] {
        MODE_NONE    = 2'd0,
        MODE_HARD    = 2'd1,
        MODE_SOFT    = 2'd2,
        MODE_GARROTE = 2'd3
    } t_mode;

    typedef struct packed {
        logic signed [COEF_W-1:0] coarse;
        logic signed [COEF_W-1:0] detail_h;
        logic signed [COEF_W-1:0] detail_v;
        logic signed [COEF_W-1:0] detail_d;
    } t_in_item;

    typedef struct packed {
        logic signed [COEF_W-1:0] pixel_top_left;
        logic signed [COEF_W-1:0] pixel_top_right;
        logic signed [COEF_W-1:0] pixel_bottom_left;
        logic signed [COEF_W-1:0] pixel_bottom_right;
    } t_out_item;

endpackage

// File: rtl/haar_inverse_with_shrinkage_top.sv
// inverse 2x2 haar block with optional hard, soft or garrote shrinkage of the details
//
// input channel: i_in_valid / o_in_stall carry one haar block (coarse and three
// details) per transfer; output channel: o_out_valid / i_out_stall carry the four
// reconstructed pixels per transfer, one result per input block.
// configuration: i_cfg_valid / o_cfg_ready with i_cfg_index and i_cfg_data;
// index 0 is the shrink mode, index 1 the threshold, other indexes are ignored.
// o_cfg_ready is always high; write only while no block is in flight.
// throughput: one block per cycle while the output does not stall; the garrote
// divider resolves one quotient bit per stage.
// every block runs through the same pipeline whatever the mode.
// reset clears all valid bits, sets mode to garrote and threshold to zero.
// when the receiver stalls with a result waiting, the whole pipeline holds and
// o_in_stall rises in the same cycle; nothing is dropped or repeated.
`timescale 1ns / 1ps
module haar_inverse_with_shrinkage_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_in_valid,
    output logic                            o_in_stall,
    input  hiws_pkg::t_in_item              i_in_data,
    output logic                            o_out_valid,
    input  logic                            i_out_stall,
    output hiws_pkg::t_out_item             o_out_data,
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [hiws_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [hiws_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    localparam int W  = hiws_pkg::COEF_W;
    localparam int QW = W - 1;

    hiws_pkg::t_mode     r_mode;
    logic [hiws_pkg::THR_W-1:0] r_thr;
    logic [QW-1:0]       t;
    logic [2*QW-1:0]     r_tsq;
    logic                en;

    assign t  = r_thr[QW-1:0];
    assign en = !(o_out_valid && i_out_stall);
    assign o_in_stall  = !en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= hiws_pkg::MODE_GARROTE;
            r_thr  <= '0;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                hiws_pkg::CFG_MODE: r_mode <= hiws_pkg::t_mode'(i_cfg_data[1:0]);
                hiws_pkg::CFG_THR:  r_thr  <= i_cfg_data[hiws_pkg::THR_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        r_tsq <= t * t;
    end

    // entry stage
    logic                r_v0;
    logic signed [W-1:0] r_c0;
    logic signed [W-1:0] r_x0 [3];

    // divider stages, index j holds the state after j quotient bits
    logic                r_dv [QW+1];
    logic signed [W-1:0] r_dc [QW+1];
    logic signed [W-1:0] r_dx [QW+1][3];
    logic [W-1:0]        r_dm [QW+1][3];
    logic [W-1:0]        r_dr [QW+1][3];
    logic [QW-1:0]       r_dq [QW+1][3];

    // shrink stage
    logic                r_sv;
    logic signed [W-1:0] r_sc;
    logic signed [W-1:0] r_sy [3];

    logic [W-1:0]        n_mag [3];
    logic signed [W-1:0] n_y [3];
    logic [W-1:0]        n_r [3];
    logic signed [W+1:0] n_s [4];
    logic signed [W:0]   n_h [4];
    logic signed [W-1:0] n_p [4];
    logic signed [W:0]   hi_lim;
    logic signed [W:0]   lo_lim;

    assign hi_lim = (W+1)'((1 << (W-1)) - 1);
    assign lo_lim = -hi_lim - (W+1)'(1);

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_mag[k] = r_x0[k][W-1] ? W'(-r_x0[k]) : W'(r_x0[k]);
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            n_r[k] = '0;
            n_y[k] = '0;
            if (r_mode == hiws_pkg::MODE_NONE) begin
                n_y[k] = r_dx[QW][k];
            end else if (r_dm[QW][k] > W'(t)) begin
                case (r_mode)
                    hiws_pkg::MODE_HARD: n_r[k] = r_dm[QW][k];
                    hiws_pkg::MODE_SOFT: n_r[k] = r_dm[QW][k] - W'(t);
                    default:             n_r[k] = r_dm[QW][k] - W'(r_dq[QW][k]);
                endcase
                n_y[k] = r_dx[QW][k][W-1] ? -$signed(n_r[k]) : $signed(n_r[k]);
            end
        end
    end

    always_comb begin
        n_s[0] = (W+2)'(r_sc) + (W+2)'(r_sy[0]) + (W+2)'(r_sy[1]) + (W+2)'(r_sy[2]);
        n_s[1] = (W+2)'(r_sc) - (W+2)'(r_sy[0]) + (W+2)'(r_sy[1]) - (W+2)'(r_sy[2]);
        n_s[2] = (W+2)'(r_sc) + (W+2)'(r_sy[0]) - (W+2)'(r_sy[1]) - (W+2)'(r_sy[2]);
        n_s[3] = (W+2)'(r_sc) - (W+2)'(r_sy[0]) - (W+2)'(r_sy[1]) + (W+2)'(r_sy[2]);
        for (int i = 0; i < 4; i++) begin
            n_h[i] = n_s[i][W+1:1];
            if (n_h[i] > hi_lim) begin
                n_p[i] = hi_lim[W-1:0];
            end else if (n_h[i] < lo_lim) begin
                n_p[i] = lo_lim[W-1:0];
            end else begin
                n_p[i] = n_h[i][W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v0 <= 1'b0;
            for (int j = 0; j <= QW; j++) begin
                r_dv[j] <= 1'b0;
            end
            r_sv        <= 1'b0;
            o_out_valid <= 1'b0;
        end else if (en) begin
            r_v0 <= i_in_valid;
            r_dv[0] <= r_v0;
            for (int j = 1; j <= QW; j++) begin
                r_dv[j] <= r_dv[j-1];
            end
            r_sv        <= r_dv[QW];
            o_out_valid <= r_sv;
        end
    end

    always_ff @(posedge i_clk) begin
        logic [W:0] trial;
        if (en) begin
            r_c0    <= i_in_data.coarse;
            r_x0[0] <= i_in_data.detail_h;
            r_x0[1] <= i_in_data.detail_v;
            r_x0[2] <= i_in_data.detail_d;
            r_dc[0] <= r_c0;
            for (int k = 0; k < 3; k++) begin
                r_dx[0][k] <= r_x0[k];
                r_dm[0][k] <= n_mag[k];
                r_dr[0][k] <= W'(r_tsq[2*QW-1:QW]);
                r_dq[0][k] <= '0;
            end
            for (int j = 1; j <= QW; j++) begin
                r_dc[j] <= r_dc[j-1];
                for (int k = 0; k < 3; k++) begin
                    trial = {r_dr[j-1][k], r_tsq[QW-j]};
                    r_dx[j][k] <= r_dx[j-1][k];
                    r_dm[j][k] <= r_dm[j-1][k];
                    if (trial >= {1'b0, r_dm[j-1][k]}) begin
                        r_dr[j][k] <= W'(trial - {1'b0, r_dm[j-1][k]});
                        r_dq[j][k] <= {r_dq[j-1][k][QW-2:0], 1'b1};
                    end else begin
                        r_dr[j][k] <= trial[W-1:0];
                        r_dq[j][k] <= {r_dq[j-1][k][QW-2:0], 1'b0};
                    end
                end
            end
            r_sc <= r_dc[QW];
            for (int k = 0; k < 3; k++) begin
                r_sy[k] <= n_y[k];
            end
            o_out_data.pixel_top_left     <= n_p[0];
            o_out_data.pixel_top_right    <= n_p[1];
            o_out_data.pixel_bottom_left  <= n_p[2];
            o_out_data.pixel_bottom_right <= n_p[3];
        end
    end

    a_accept_enters: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_v0)
        else $error("accepted block not captured");

    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> ($stable(r_dv[QW]) && $stable(r_sv)))
        else $error("pipeline moved while stalled");

    a_shrink_to_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (en && r_sv) |=> o_out_valid)
        else $error("result lost at output register");

endmodule
